FILE: rtl/kbrt_pkg.sv
package kbrt_pkg;

    typedef struct packed {
        logic [7:0] report_state;
        logic [7:0] raw_code;
    } kbrt_in_t;

    typedef struct packed {
        logic       key_pressed;
        logic [8:0] key_code;
        logic [6:0] ascii_value;
        logic [2:0] modifier_flags;
    } kbrt_out_t;

    // modifier request and answer between top level and mask logic
    typedef struct packed {
        logic       update;
        logic       down;
        logic [7:0] raw_code;
    } kbrt_mod_req_t;

    typedef struct packed {
        logic       is_mod;
        logic [8:0] code;
        logic [2:0] mask_new;
    } kbrt_mod_info_t;

    localparam logic [7:0] ST_PRESSED  = 8'd1;
    localparam logic [7:0] ST_HELD     = 8'd2;
    localparam logic [7:0] ST_RELEASED = 8'd3;

    localparam logic [7:0] RC_ALT      = 8'hA1;
    localparam logic [7:0] RC_LSHIFT   = 8'hA2;
    localparam logic [7:0] RC_RSHIFT   = 8'hA3;
    localparam logic [7:0] RC_CTRL     = 8'hA5;

    localparam logic [2:0] MOD_SHIFT   = 3'b001;
    localparam logic [2:0] MOD_CTRL    = 3'b010;
    localparam logic [2:0] MOD_ALT     = 3'b100;

    localparam logic [8:0] KC_RSHIFT   = 9'd303;
    localparam logic [8:0] KC_LSHIFT   = 9'd304;
    localparam logic [8:0] KC_CTRL     = 9'd305;
    localparam logic [8:0] KC_ALT      = 9'd307;
    localparam logic [8:0] KC_F1       = 9'd282;
    localparam logic [8:0] KC_F10      = 9'd291;

endpackage

FILE: rtl/kbrt_key_table.sv
module kbrt_key_table
    import kbrt_pkg::*;
(
    input  logic [7:0] raw_code,
    output logic       mapped,
    output logic [8:0] key_code,
    output logic [6:0] ascii_value
);

    always_comb begin
        mapped      = 1'b1;
        key_code    = '0;
        ascii_value = '0;
        priority if (raw_code >= 8'h20 && raw_code < 8'h7F) begin
            key_code    = {1'b0, raw_code};
            ascii_value = raw_code[6:0];
        end else if (raw_code >= 8'h81 && raw_code <= 8'h89) begin
            // f1 to f9
            key_code = KC_F1 + {5'd0, raw_code[3:0]} - 9'd1;
        end else begin
            unique case (raw_code)
                8'h90: key_code = KC_F10;
                8'h08: begin key_code = 9'd8;  ascii_value = 7'd8;  end
                8'h09: begin key_code = 9'd9;  ascii_value = 7'd9;  end
                8'h0A: begin key_code = 9'd13; ascii_value = 7'd13; end
                8'hB1: begin key_code = 9'd27; ascii_value = 7'd27; end
                8'hB5: key_code = 9'd273;
                8'hB6: key_code = 9'd274;
                8'hB7: key_code = 9'd275;
                8'hB4: key_code = 9'd276;
                8'hD1: key_code = 9'd277;
                8'hD2: key_code = 9'd278;
                8'hD5: key_code = 9'd279;
                8'hD6: key_code = 9'd280;
                8'hD7: key_code = 9'd281;
                8'hD4: key_code = 9'd127;
                8'hD0: key_code = 9'd19;
                8'hC1: key_code = 9'd301;
                default: mapped = 1'b0;
            endcase
        end
    end

endmodule

FILE: rtl/kbrt_modifier.sv
module kbrt_modifier
    import kbrt_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  kbrt_mod_req_t  req,
    output kbrt_mod_info_t info
);

    logic [2:0] mask_reg;
    logic [2:0] mask_next;
    logic [2:0] mod_bit;

    always_comb begin
        info.is_mod = 1'b1;
        mod_bit     = '0;
        info.code   = '0;
        unique case (req.raw_code)
            RC_LSHIFT: begin mod_bit = MOD_SHIFT; info.code = KC_LSHIFT; end
            RC_RSHIFT: begin mod_bit = MOD_SHIFT; info.code = KC_RSHIFT; end
            RC_CTRL:   begin mod_bit = MOD_CTRL;  info.code = KC_CTRL;   end
            RC_ALT:    begin mod_bit = MOD_ALT;   info.code = KC_ALT;    end
            default:   info.is_mod = 1'b0;
        endcase
        // either shift release clears the shared shift bit
        info.mask_new = req.down ? (mask_reg | mod_bit) : (mask_reg & ~mod_bit);
        mask_next     = (req.update && info.is_mod) ? info.mask_new : mask_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    a_mask_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.update && info.is_mod) |=> $stable(mask_reg))
        else $error("modifier mask changed without a modifier item");

endmodule

FILE: rtl/keyboard_report_translator_unit.sv
// each item waits in the input register until the result register can take its result
// throughput: one item per cycle while m_ready stays high, set by the input register and the result register
// items with an ignored state or an unknown keycode give no result item
// reset (aresetn low, synchronous) empties both registers and clears the modifier mask
module keyboard_report_translator_unit
    import kbrt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  kbrt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output kbrt_out_t m_data
);

    logic           in_valid_reg;
    logic           in_valid_next;
    kbrt_in_t       in_data_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    kbrt_out_t      out_data_reg;
    kbrt_out_t      out_data_next;

    logic           out_free;
    logic           consume;
    logic           state_ok;
    logic           down;
    logic           mapped;
    logic [8:0]     tbl_code;
    logic [6:0]     tbl_ascii;
    logic           result_ok;
    kbrt_mod_req_t  mod_req;
    kbrt_mod_info_t mod_info;

    kbrt_key_table u_key_table (
        .raw_code    (in_data_reg.raw_code),
        .mapped      (mapped),
        .key_code    (tbl_code),
        .ascii_value (tbl_ascii)
    );

    kbrt_modifier u_modifier (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .info    (mod_info)
    );

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        s_ready  = !in_valid_reg || out_free;
        consume  = in_valid_reg && out_free;

        state_ok = (in_data_reg.report_state == ST_PRESSED) ||
                   (in_data_reg.report_state == ST_HELD) ||
                   (in_data_reg.report_state == ST_RELEASED);
        down     = (in_data_reg.report_state != ST_RELEASED);

        mod_req.update   = consume && state_ok;
        mod_req.down     = down;
        mod_req.raw_code = in_data_reg.raw_code;

        result_ok = state_ok && (mod_info.is_mod || mapped);

        out_data_next.key_pressed    = down;
        out_data_next.key_code       = mod_info.is_mod ? mod_info.code : tbl_code;
        out_data_next.ascii_value    = mod_info.is_mod ? 7'd0 : tbl_ascii;
        out_data_next.modifier_flags = mod_info.mask_new;

        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = out_free ? (in_valid_reg && result_ok) : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (consume && result_ok) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_shift_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.key_code == KC_LSHIFT || m_data.key_code == KC_RSHIFT))
        |-> (m_data.modifier_flags[0] == m_data.key_pressed))
        else $error("shift item with wrong shift flag");

    a_ctrl_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.key_code == KC_CTRL)
        |-> (m_data.modifier_flags[1] == m_data.key_pressed))
        else $error("ctrl item with wrong ctrl flag");

    a_alt_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.key_code == KC_ALT)
        |-> (m_data.modifier_flags[2] == m_data.key_pressed))
        else $error("alt item with wrong alt flag");

    a_ascii_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ascii_value != 7'd0)
        |-> (m_data.key_code == {2'b00, m_data.ascii_value}))
        else $error("ascii value disagrees with key code");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && !result_ok) |=> (m_valid == 1'b0))
        else $error("result item from an item that gives none");

endmodule
